@@ sv/ftnl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ftnl_pkg
// Shared types and constants of the flat trie name lookup: table geometry,
// node entry layout and the control states.
// ----------------------------------------------------------------------------
package ftnl_pkg;

  localparam int NODES      = 1024;
  localparam int NODE_W     = $clog2(NODES);
  localparam int OFFSET_MAX = 255;
  localparam int ID_COUNT   = 256;

  localparam int CHAR_W  = 8;
  localparam int OFF_W   = 8;
  localparam int ID_W    = 8;
  localparam int INDEX_W = 10;

  // sum of a node position and an offset, wide enough never to wrap
  localparam int SUM_W = ((NODE_W > OFF_W) ? NODE_W : OFF_W) + 1;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [OFF_W-1:0]  offset;
    logic              terminal;
    logic              has_child;
    logic [CHAR_W-1:0] chr;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_t;

endpackage : ftnl_pkg
`default_nettype wire

@@ sv/flat_trie_name_lookup.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// flat_trie_name_lookup
// Case-insensitive name matcher over a flattened trie held in one RAM.
//
// Requests arrive on in_valid/in_ready. A request with cmd = 0 writes one
// node entry (character, has-child, terminal, sibling offset, identifier).
// A request with cmd = 1 presents one name character; it reads the
// current node and walks sibling offsets, one RAM read per cycle, until
// the character matches or the walk fails. A character of a name that has
// already failed visits no nodes. Characters other than the last give no
// result. The last character gives one result (found, header_id) on
// out_valid/out_ready, after which the walk returns to the root entry.
// Results sit in an output register: new requests are accepted while a
// result waits; a further result stalls the block until the receiver takes
// the one held.
// Reset (rst, synchronous) returns to the root entry and clears the failed
// flag and the output valid flag; the table contents are not cleared.
// ----------------------------------------------------------------------------
module flat_trie_name_lookup
  import ftnl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               cmd,
  input  wire logic [INDEX_W-1:0] entry_index,
  input  wire logic [CHAR_W-1:0]  entry_char,
  input  wire logic               entry_has_child,
  input  wire logic               entry_terminal,
  input  wire logic [OFF_W-1:0]   entry_offset,
  input  wire logic [ID_W-1:0]    entry_id,
  input  wire logic [CHAR_W-1:0]  lookup_char,
  input  wire logic               lookup_last,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    found,
  output logic [ID_W-1:0]         header_id
);

  state_t state, state_next;

  logic [NODE_W-1:0] current_node;
  logic              lookup_failed;
  logic [NODE_W-1:0] cur;
  logic [CHAR_W-1:0] key_char;
  logic              key_last;
  logic              res_found;
  logic [ID_W-1:0]   res_id;

  logic              accept;
  logic              out_load;
  logic [CHAR_W-1:0] lower_char;

  logic              ram_we;
  logic [NODE_W-1:0] ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;
  entry_t            wr_entry;
  entry_t            rd_entry;

  logic [SUM_W-1:0]  jump_sum;
  logic [SUM_W-1:0]  child_sum;
  logic              hit;
  logic              jump_ok;
  logic              child_ok;

  assign accept = in_valid && in_ready;

  // Fold ASCII upper case to lower case
  always_comb begin
    lower_char = lookup_char;
    if (lookup_char >= 8'h41 && lookup_char <= 8'h5A) begin
      lower_char = lookup_char + 8'h20;
    end
  end

  // Build the entry to store: clamp the offset, wrap the identifier
  always_comb begin
    wr_entry.chr       = entry_char;
    wr_entry.has_child = entry_has_child;
    wr_entry.terminal  = entry_terminal;
    wr_entry.offset    = (32'(entry_offset) > OFFSET_MAX) ? OFF_W'(OFFSET_MAX) : entry_offset;
    wr_entry.id        = ID_W'(32'(entry_id) % ID_COUNT);
  end

  // Decode the node read in the previous cycle
  assign rd_entry  = entry_t'(ram_rd_data);
  assign hit       = (rd_entry.chr == key_char);
  assign jump_sum  = SUM_W'(cur) + SUM_W'(rd_entry.offset);
  assign child_sum = SUM_W'(cur) + SUM_W'(1);
  assign jump_ok   = (rd_entry.offset != '0) && (32'(jump_sum) < NODES);
  assign child_ok  = rd_entry.has_child && (32'(child_sum) < NODES);

  ftnl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (NODE_W'(entry_index)),
    .wr_data (wr_entry),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && cmd == CMD_LOOKUP) begin
          if (lookup_failed) begin
            state_next = lookup_last ? ST_EMIT : ST_IDLE;
          end else begin
            state_next = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (!hit && jump_ok) begin
          state_next = ST_WALK;
        end else begin
          state_next = key_last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    in_ready    = 1'b0;
    ram_we      = 1'b0;
    out_load    = 1'b0;
    ram_rd_addr = current_node;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        ram_we   = in_valid && cmd == CMD_WRITE && 32'(entry_index) < NODES;
      end
      ST_WALK: begin
        ram_rd_addr = jump_sum[NODE_W-1:0];
      end
      ST_EMIT: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk progress: the current node and failed flag persist across characters
  always_ff @(posedge clk) begin
    if (rst) begin
      current_node  <= '0;
      lookup_failed <= 1'b0;
    end else if (state == ST_WALK) begin
      if (hit) begin
        if (!key_last) begin
          if (child_ok) begin
            current_node <= child_sum[NODE_W-1:0];
          end else begin
            lookup_failed <= 1'b1;
          end
        end
      end else if (!jump_ok) begin
        lookup_failed <= 1'b1;
      end
    end else if (out_load) begin
      current_node  <= '0;
      lookup_failed <= 1'b0;
    end
  end

  // Per-character working registers and the pending result
  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_LOOKUP) begin
      key_char  <= lower_char;
      key_last  <= lookup_last;
      cur       <= current_node;
      res_found <= 1'b0;
      res_id    <= '0;
    end else if (state == ST_WALK) begin
      if (hit) begin
        res_found <= rd_entry.terminal;
        res_id    <= rd_entry.terminal ? rd_entry.id : '0;
      end else if (jump_ok) begin
        cur <= jump_sum[NODE_W-1:0];
      end
    end
  end

  // Output register: hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found     <= res_found;
      header_id <= res_id;
    end
  end

  // A miss always reports identifier zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> header_id == '0)
    else $error("miss reported with a non-zero identifier");

  // A failed name never starts a walk
  assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE && accept && cmd == CMD_LOOKUP && lookup_failed |=> state != ST_WALK)
    else $error("walk started on a failed name");

  // Delivering a result returns the walk to the root entry
  assert property (@(posedge clk) disable iff (rst)
    out_load |=> current_node == '0 && !lookup_failed)
    else $error("walk not returned to the root after a result");

endmodule : flat_trie_name_lookup
`default_nettype wire

@@ sv/ftnl_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ftnl_ram
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read.
// ----------------------------------------------------------------------------
module ftnl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule : ftnl_ram
`default_nettype wire
